>>> rtl/sha1dsh_pkg.sv
// Shared types, constants and helper functions for the digit string SHA-1 hash block.
`default_nettype none

package sha1dsh_pkg;

  // Number of compression rounds and words in the rolling message schedule.
  localparam int unsigned NumRounds   = 80;
  localparam int unsigned SchedWords  = 16;
  localparam int unsigned RoundBits   = 7;

  // Message layout constants for a 16-byte message in one block.
  localparam logic [7:0]  DigitBase   = 8'h30;
  localparam logic [31:0] PadMarker   = 32'h8000_0000;
  localparam logic [31:0] MsgBits     = 32'd128;

  // Initial hash value.
  localparam logic [31:0] Iv0 = 32'h6745_2301;
  localparam logic [31:0] Iv1 = 32'hEFCD_AB89;
  localparam logic [31:0] Iv2 = 32'h98BA_DCFE;
  localparam logic [31:0] Iv3 = 32'h1032_5476;
  localparam logic [31:0] Iv4 = 32'hC3D2_E1F0;

  // Round constants.
  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  // Round boundaries between the four round groups.
  localparam logic [RoundBits-1:0] RoundGrp1 = 7'd20;
  localparam logic [RoundBits-1:0] RoundGrp2 = 7'd40;
  localparam logic [RoundBits-1:0] RoundGrp3 = 7'd60;
  localparam logic [RoundBits-1:0] RoundLast = RoundBits'(NumRounds - 1);

  // Control handed from the sequencer to the schedule cells and the round unit.
  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [RoundBits-1:0] rnd;
  } ctrl_t;

  // Packs four nibbles into one big-endian word of ASCII characters.
  function automatic logic [31:0] pack_chars(input logic [15:0] nibs);
    logic [31:0] word;
    word = '0;
    for (int k = 0; k < 4; k++) begin
      word[31-8*k -: 8] = DigitBase + {4'h0, nibs[4*k +: 4]};
    end
    return word;
  endfunction

  // True when any of the four nibbles is above nine.
  function automatic logic has_bad_nibble(input logic [15:0] nibs);
    logic bad;
    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      bad = bad | (nibs[4*k +: 4] > 4'd9);
    end
    return bad;
  endfunction

  // Round constant for a round index.
  function automatic logic [31:0] round_k(input logic [RoundBits-1:0] rnd);
    logic [31:0] k;
    if (rnd < RoundGrp1) begin
      k = K0;
    end else if (rnd < RoundGrp2) begin
      k = K1;
    end else if (rnd < RoundGrp3) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  // Left rotate helpers.
  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sha1dsh_sched_cell.sv
// One word cell of the rolling message schedule chain.
`default_nettype none

module sha1dsh_sched_cell (
  input  wire logic                 clk,
  input  wire sha1dsh_pkg::ctrl_t   ctrl,
  input  wire logic [31:0]          load_word,
  input  wire logic [31:0]          shift_in,
  output logic [31:0]               word
);

  // Load the message word at start, then take the neighbor's word each round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= load_word;
    end else if (ctrl.step) begin
      word <= shift_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha1dsh_round.sv
// SHA-1 compression round unit holding the five working variables.
`default_nettype none

module sha1dsh_round (
  input  wire logic                 clk,
  input  wire sha1dsh_pkg::ctrl_t   ctrl,
  input  wire logic [31:0]          wt,
  output logic [31:0]               a,
  output logic [31:0]               b,
  output logic [31:0]               c,
  output logic [31:0]               d,
  output logic [31:0]               e
);

  logic [31:0] f;
  logic [31:0] a_next;

  // Round function selected by the round group.
  always_comb begin
    if (ctrl.rnd < sha1dsh_pkg::RoundGrp1) begin
      f = d ^ (b & (c ^ d));
    end else if (ctrl.rnd < sha1dsh_pkg::RoundGrp2) begin
      f = b ^ c ^ d;
    end else if (ctrl.rnd < sha1dsh_pkg::RoundGrp3) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    a_next = sha1dsh_pkg::rotl5(a) + f + e + sha1dsh_pkg::round_k(ctrl.rnd) + wt;
  end

  // Working variables start from the initial hash value and advance once per round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a <= sha1dsh_pkg::Iv0;
      b <= sha1dsh_pkg::Iv1;
      c <= sha1dsh_pkg::Iv2;
      d <= sha1dsh_pkg::Iv3;
      e <= sha1dsh_pkg::Iv4;
    end else if (ctrl.step) begin
      a <= a_next;
      b <= a;
      c <= sha1dsh_pkg::rotl30(b);
      d <= c;
      e <= d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha1_digit_string_hash.sv
// Top level of the digit string SHA-1 hash block: sequencer, schedule chain and output register.
//
// Usage: an item on the slave stream carries two 32-bit words. Their sixteen
// nibbles form a 16-character ASCII message (second word first, low nibble
// first, each nibble n as byte 0x30+n), which is hashed as one SHA-1 block.
// The master stream returns the five digest words in tdata and a flag in
// tuser that is set when any nibble was above nine.
// Throughput: one item at a time. After acceptance the round unit runs 80
// rounds, one per cycle, fed by a chain of 16 schedule cells that shifts one
// word per cycle; a final state then adds the initial hash value. s_tready
// rises again in the same cycle that the result is loaded.
// The result sits in an output register; if the receiver stalls, the block
// may take the next item and runs it, but holds in its final cycle until
// the output register is free.
// Reset clears the sequencer and the output valid and holds s_tready low;
// no item is held over.
`default_nettype none

module sha1_digit_string_hash (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [63:0]   s_tdata,   // first_number [31:0], second_number [63:32]
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [159:0]       m_tdata,   // hash_word_0 [31:0] .. hash_word_4 [159:128]
  output logic               m_tuser    // bad_digit [0]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  localparam int unsigned NW = sha1dsh_pkg::SchedWords;

  state_t                              state;
  logic [sha1dsh_pkg::RoundBits-1:0]   rnd;
  logic                                bad;
  sha1dsh_pkg::ctrl_t                  ctrl;
  logic                                accept;
  logic                                out_free;
  logic [31:0]                         first_number;
  logic [31:0]                         second_number;
  logic [31:0]                         load_words [NW];
  logic [31:0]                         cell_words [NW];
  logic [31:0]                         shift_words [NW];
  logic [31:0]                         new_word;
  logic [31:0]                         a, b, c, d, e;

  assign first_number  = s_tdata[31:0];
  assign second_number = s_tdata[63:32];

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ctrl.load = accept;
  assign ctrl.step = (state == ST_RUN);
  assign ctrl.rnd  = rnd;

  // Padded message block for the schedule cells.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      load_words[i] = '0;
    end
    load_words[0]    = sha1dsh_pkg::pack_chars(second_number[15:0]);
    load_words[1]    = sha1dsh_pkg::pack_chars(second_number[31:16]);
    load_words[2]    = sha1dsh_pkg::pack_chars(first_number[15:0]);
    load_words[3]    = sha1dsh_pkg::pack_chars(first_number[31:16]);
    load_words[4]    = sha1dsh_pkg::PadMarker;
    load_words[NW-1] = sha1dsh_pkg::MsgBits;
  end

  // Next schedule word enters at the top of the chain.
  assign new_word = sha1dsh_pkg::rotl1(cell_words[13] ^ cell_words[8] ^
                                        cell_words[2] ^ cell_words[0]);

  // Chain of schedule cells; cell zero holds the word for the current round.
  for (genvar i = 0; i < NW; i++) begin : g_cell
    if (i == NW - 1) begin : g_top
      assign shift_words[i] = new_word;
    end else begin : g_mid
      assign shift_words[i] = cell_words[i+1];
    end

    sha1dsh_sched_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_word (load_words[i]),
      .shift_in  (shift_words[i]),
      .word      (cell_words[i])
    );
  end

  sha1dsh_round u_round (
    .clk  (clk),
    .ctrl (ctrl),
    .wt   (cell_words[0]),
    .a    (a),
    .b    (b),
    .c    (c),
    .d    (d),
    .e    (e)
  );

  // Sequencer, flag capture and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rnd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rnd   <= '0;
            state <= ST_RUN;
            bad   <= sha1dsh_pkg::has_bad_nibble(first_number[15:0]) |
                     sha1dsh_pkg::has_bad_nibble(first_number[31:16]) |
                     sha1dsh_pkg::has_bad_nibble(second_number[15:0]) |
                     sha1dsh_pkg::has_bad_nibble(second_number[31:16]);
          end
        end
        ST_RUN: begin
          if (rnd == sha1dsh_pkg::RoundLast) begin
            state <= ST_FIN;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tdata[31:0]    <= a + sha1dsh_pkg::Iv0;
            m_tdata[63:32]   <= b + sha1dsh_pkg::Iv1;
            m_tdata[95:64]   <= c + sha1dsh_pkg::Iv2;
            m_tdata[127:96]  <= d + sha1dsh_pkg::Iv3;
            m_tdata[159:128] <= e + sha1dsh_pkg::Iv4;
            m_tuser          <= bad;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the digit string SHA-1 hash block.
`timescale 1ns / 100ps

module tb_top;

  // Expected outcome of one hashed item, word 0 in the low bits as on m_tdata.
  typedef struct packed {
    logic [4:0][31:0] word;
    logic             bad;
  } digest_t;

  localparam int NumItems  = 1350;
  localparam int DrainWait = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata  = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [159:0]  m_tdata;
  logic          m_tuser;

  logic [63:0]   pending_items[$];
  digest_t       expected_digests[$];
  int            total_items = 0;
  int            items_taken = 0;
  int            errors = 0;
  logic          item_taken_last = 1'b0;

  sha1_digit_string_hash DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // SHA-1 over the sixteen ASCII characters that the two words spell out.
  function automatic digest_t hash_digit_string(input logic [31:0] first,
                                                input logic [31:0] second);
    logic [63:0] digits;
    logic [31:0] sched[0:79];
    logic [31:0] a, b, c, d, e, f, k, sum;
    digest_t     r;
    digits = {first, second};
    r = '0;
    for (int i = 0; i < 80; i++) sched[i] = '0;
    // Nibble n becomes byte 0x30+n, which never carries into the high nibble.
    for (int i = 0; i < 16; i++) begin
      sched[i / 4][31 - 8 * (i % 4) -: 8] = {4'h3, digits[4 * i +: 4]};
      if (digits[4 * i +: 4] > 4'd9) r.bad = 1'b1;
    end
    sched[4]  = 32'h8000_0000;
    sched[15] = 32'd128;
    for (int i = 16; i < 80; i++) begin
      sched[i] = rotate_left(sched[i - 3] ^ sched[i - 8] ^ sched[i - 14] ^ sched[i - 16], 1);
    end
    a = 32'h6745_2301;
    b = 32'hEFCD_AB89;
    c = 32'h98BA_DCFE;
    d = 32'h1032_5476;
    e = 32'hC3D2_E1F0;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      sum = rotate_left(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = sum;
    end
    r.word[0] = a + 32'h6745_2301;
    r.word[1] = b + 32'hEFCD_AB89;
    r.word[2] = c + 32'h98BA_DCFE;
    r.word[3] = d + 32'h1032_5476;
    r.word[4] = e + 32'hC3D2_E1F0;
    return r;
  endfunction

  // A word made only of decimal nibbles.
  function automatic logic [31:0] decimal_word();
    logic [31:0] w;
    for (int i = 0; i < 8; i++) w[4 * i +: 4] = 4'($urandom_range(9));
    return w;
  endfunction

  // Idle percentages step through three phases as items are taken.
  function automatic int sender_idle_pct(input int taken);
    if (taken < total_items / 3) return 27;
    else if (taken < 2 * total_items / 3) return 81;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct(input int taken);
    if (taken < total_items / 3) return 81;
    else if (taken < 2 * total_items / 3) return 27;
    else return 0;
  endfunction

  function automatic void queue_item(input logic [31:0] first, input logic [31:0] second);
    pending_items.push_back({second, first});
    total_items++;
  endfunction

  // Stimulus: directed corner items, then random ones; then wait for the drain.
  initial begin
    logic [31:0] f, s;
    int          pos;
    // Extremes, the largest all-decimal value and some mixed patterns.
    queue_item(32'h0000_0000, 32'h0000_0000);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(32'h9999_9999, 32'h9999_9999);
    queue_item(32'h1234_5678, 32'h9012_3456);
    queue_item(32'h0909_0909, 32'h9090_9090);
    queue_item(32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(32'hAAAA_AAAA, 32'h0000_0000);
    queue_item(32'hF0F0_F0F0, 32'h0F0F_0F0F);
    // Single bad nibble at each word end; an all-decimal item; an all-bad first word.
    queue_item(32'h9999_9999, 32'h9999_999A);
    queue_item(32'h9999_9999, 32'hA999_9999);
    queue_item(32'h9999_999A, 32'h9999_9999);
    queue_item(32'hA999_9999, 32'h9999_9999);
    queue_item(32'h0000_000F, 32'h0000_0000);
    queue_item(32'h0000_0000, 32'hF000_0000);
    queue_item(32'h3333_3333, 32'h5555_5555);
    queue_item(32'hCCCC_CCCC, 32'h6666_6666);
    // Random part: mostly decimal strings, some with one bad nibble, some raw noise.
    while (total_items < NumItems) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          f = decimal_word();
          s = decimal_word();
        end
        5, 6: begin
          f = decimal_word();
          s = decimal_word();
          pos = $urandom_range(15);
          if (pos < 8) s[4 * pos +: 4] = 4'($urandom_range(15, 10));
          else f[4 * (pos - 8) +: 4] = 4'($urandom_range(15, 10));
        end
        default: begin
          f = $urandom;
          s = $urandom;
        end
      endcase
      queue_item(f, s);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken < total_items || expected_digests.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Input side: record acceptance and predict the digest of each taken item.
  always @(posedge clk) begin
    item_taken_last <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_digests.push_back(hash_digit_string(s_tdata[31:0], s_tdata[63:32]));
      items_taken <= items_taken + 1;
    end
  end

  // Driver: present the next item once the current one has been taken.
  always @(negedge clk) begin
    logic        next_valid;
    logic [63:0] next_data;
    next_valid = s_tvalid;
    next_data  = s_tdata;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!s_tvalid || item_taken_last) begin
      next_valid = 1'b0;
      if (pending_items.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct(items_taken)) begin
        next_data  = pending_items.pop_front();
        next_valid = 1'b1;
      end
    end
    s_tvalid <= next_valid;
    s_tdata  <= next_data;
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_idle_pct(items_taken));
  end

  // Monitor: compare each delivered digest with the oldest prediction.
  always @(posedge clk) begin
    digest_t exp_digest;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_digests.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h bad_digit %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_digest = expected_digests.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (m_tdata[32 * i +: 32] !== exp_digest.word[i]) begin
            $display("%0t: hash_word_%0d mismatch, expected %h actual %h",
                     $time, i, exp_digest.word[i], m_tdata[32 * i +: 32]);
            errors++;
          end
        end
        if (m_tuser !== exp_digest.bad) begin
          $display("%0t: bad_digit mismatch, expected %b actual %b",
                   $time, exp_digest.bad, m_tuser);
          errors++;
        end
      end
    end
  end

endmodule
